[sv/mie_pkg.sv]
// Package for the extended Euclidean modular inverse block.
// Holds the default width, controller states and the control/status bundles.
// Used by mie_ctrl, mie_dpath and modular_inverse_ext_euclid.
package mie_pkg;

  // Default operand width
  localparam int unsigned DEF_WIDTH = 32;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FIN_T,
    ST_FIN_OUT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture value and modulus, reset coefficients
    logic div_init;  // start a quotient/remainder step
    logic div_step;  // one bit of restoring division plus multiply-accumulate
    logic update;    // shift remainders and coefficients by one Euclid step
    logic fin_t;     // reduce final coefficient modulo the modulus
    logic out_load;  // write result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic r_zero;    // current remainder is zero, loop ends
    logic div_last;  // last bit of the division step
  } status_t;

endpackage

[sv/mie_ctrl.sv]
// Controller state machine for the modular inverse block.
// Sequences Euclid steps over the datapath; depends on mie_pkg.
module mie_ctrl
  import mie_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_free_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance state and issue commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.r_zero) begin
          state_d = ST_FIN_T;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_CHECK;
      end
      ST_FIN_T: begin
        cmd_o.fin_t = 1'b1;
        state_d     = ST_FIN_OUT;
      end
      ST_FIN_OUT: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/mie_dpath.sv]
// Datapath for the modular inverse block: remainder and coefficient registers,
// a bit-serial restoring divider with a fused shift-add multiply, final reduction.
// Depends on mie_pkg for the command and status bundles.
module mie_dpath
  import mie_pkg::*;
#(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] value_i,
  input  logic [WIDTH-1:0] modulus_i,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  output logic [WIDTH-1:0] inverse_o,
  output logic [WIDTH-1:0] divisor_o,
  output logic             invertible_o
);

  localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] m_q, old_r_q, r_q, old_s_q, s_q;
  logic [WIDTH-1:0] rem_q, dvd_q, acc_q, t_q;
  logic [CW-1:0]    cnt_q;
  logic             odd_q;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH-1:0] rem_diff;
  logic             q_bit;
  logic [WIDTH-1:0] rem_d, acc_d, t_d;
  logic             has_inv;

  // One restoring division bit; the quotient bit also drives acc = acc*2 + q_bit*s
  // The difference is only used when it is below r, so WIDTH bits hold it
  always_comb begin
    rem_sh   = {rem_q, dvd_q[WIDTH-1]};
    rem_diff = rem_sh[WIDTH-1:0] - r_q;
    q_bit    = (rem_sh >= {1'b0, r_q});
    rem_d    = q_bit ? rem_diff : rem_sh[WIDTH-1:0];
    acc_d    = {acc_q[WIDTH-2:0], 1'b0} + (q_bit ? s_q : '0);
  end

  // Reduce final coefficient; its magnitude never exceeds the modulus
  assign t_d = (old_s_q >= m_q) ? (old_s_q - m_q) : old_s_q;

  // Registers of the Euclid loop
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q     <= modulus_i;
      old_r_q <= value_i;
      r_q     <= modulus_i;
      old_s_q <= {{(WIDTH-1){1'b0}}, 1'b1};
      s_q     <= '0;
      odd_q   <= 1'b0;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      dvd_q <= old_r_q;
      acc_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
      acc_q <= acc_d;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.update) begin
      old_r_q <= r_q;
      r_q     <= rem_q;
      old_s_q <= s_q;
      s_q     <= old_s_q + acc_q;
      odd_q   <= ~odd_q;
    end
    if (cmd_i.fin_t) begin
      t_q <= t_d;
    end
  end

  // Report loop status
  assign status_o.r_zero   = (r_q == '0);
  assign status_o.div_last = (cnt_q == CW'(WIDTH - 1));

  // Form result; odd step count means the coefficient is negative
  assign has_inv      = (old_r_q == {{(WIDTH-1){1'b0}}, 1'b1}) && (m_q != '0);
  assign inverse_o    = !has_inv ? '0 :
                        (odd_q && (t_q != '0)) ? (m_q - t_q) : t_q;
  assign divisor_o    = old_r_q;
  assign invertible_o = (old_r_q == {{(WIDTH-1){1'b0}}, 1'b1});

endmodule

[sv/modular_inverse_ext_euclid.sv]
// Top level of the extended Euclidean modular inverse block.
// Joins mie_ctrl and mie_dpath and holds the output register; depends on mie_pkg.
//
// Usage:
//   Slave stream: s_axis_tdata carries value (low WIDTH bits) and modulus
//   (next WIDTH bits). An item is taken when s_axis_tvalid and s_axis_tready
//   are both high; s_axis_tready is high only while no item is in work.
//   Master stream: m_axis_tdata carries inverse (low) and divisor (next);
//   m_axis_tuser carries the invertible flag. One result per item.
//   Sequence: each Euclid step is a check, a bit-serial division that
//   yields one quotient bit per cycle, and an update. An item is a load,
//   its Euclid steps, a final check, the final reduction and the output
//   write. One item is in work at a time.
//   Stall: the result sits in an output register; a new item is accepted
//   while it waits, and the datapath holds its finished result until the
//   register is free.
//   Reset: rst_ni clears the controller and output valid; no clearing pass.
module modular_inverse_ext_euclid
  import mie_pkg::*;
#(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // value [WIDTH-1:0], modulus [2*WIDTH-1:WIDTH], zero pad above
  input  logic [((2*WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // inverse [WIDTH-1:0], divisor [2*WIDTH-1:WIDTH], zero pad above
  output logic [((2*WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // invertible [0]
  output logic                              m_axis_tuser
);

  localparam int unsigned DW = ((2 * WIDTH + 7) / 8) * 8;

  cmd_t             cmd;
  status_t          status;
  logic             out_free;
  logic [WIDTH-1:0] inverse, divisor;
  logic             invertible;

  logic             out_valid_q;
  logic [DW-1:0]    out_data_q;
  logic             out_user_q;

  // Output register is free when empty or being drained
  assign out_free = !out_valid_q || m_axis_tready;

  mie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mie_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .value_i      (s_axis_tdata[WIDTH-1:0]),
    .modulus_i    (s_axis_tdata[2*WIDTH-1:WIDTH]),
    .cmd_i        (cmd),
    .status_o     (status),
    .inverse_o    (inverse),
    .divisor_o    (divisor),
    .invertible_o (invertible)
  );

  // Track output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture result item
  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_data_q <= DW'({divisor, inverse});
      out_user_q <= invertible;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

[tb/sv/mie_inverse_checker.sv]
// Result checker for the extended Euclidean modular inverse block.
// Watches both stream channels, predicts each result and compares it in order.
// Needs only the stream signals of modular_inverse_ext_euclid; no package types.
module mie_inverse_checker #(
  parameter int unsigned W  = 32,
  parameter int unsigned DW = ((2*W+7)/8)*8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic          s_tready_i,
  // value [W-1:0], modulus [2*W-1:W]
  input  logic [DW-1:0] s_tdata_i,
  input  logic          m_tvalid_i,
  input  logic          m_tready_i,
  // inverse [W-1:0], divisor [2*W-1:W]
  input  logic [DW-1:0] m_tdata_i,
  // invertible [0]
  input  logic          m_tuser_i,
  output int            fail_count_o,
  output int            pending_o
);

  typedef struct packed {
    logic [W-1:0] inverse;
    logic [W-1:0] divisor;
    logic         invertible;
  } inverse_result_t;

  inverse_result_t pending_inverses[$];
  int mismatch_total = 0;

  assign fail_count_o = mismatch_total;

  // Iterative extended Euclid; coefficient magnitudes with alternating sign
  function automatic inverse_result_t euclid_inverse(logic [W-1:0] value,
                                                     logic [W-1:0] modulus);
    logic [2*W-1:0]  old_r, r, nr, q, old_s, s, ns, t;
    logic            odd;
    inverse_result_t res;
    old_r = value;
    r     = modulus;
    old_s = 1;
    s     = 0;
    odd   = 1'b0;
    while (r != 0) begin
      q     = old_r / r;
      nr    = old_r % r;
      ns    = old_s + q * s;
      old_r = r;
      r     = nr;
      old_s = s;
      s     = ns;
      odd   = ~odd;
    end
    res.inverse = '0;
    if (old_r == 1 && modulus != 0) begin
      t = old_s % modulus;
      // a negative coefficient folds back into 0..modulus-1
      if (odd && t != 0) begin
        t = modulus - t;
      end
      res.inverse = t[W-1:0];
    end
    res.divisor    = old_r[W-1:0];
    res.invertible = (old_r == 1);
    return res;
  endfunction

  // Count a failure, report only the first few
  task automatic note_failure(input string msg);
    mismatch_total++;
    if (mismatch_total <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // Compare results first, then queue the prediction for a newly taken item
  always @(posedge clk_i or negedge rst_ni) begin : watch
    inverse_result_t want;
    inverse_result_t got;
    if (!rst_ni) begin
      pending_inverses.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.inverse    = m_tdata_i[W-1:0];
        got.divisor    = m_tdata_i[2*W-1:W];
        got.invertible = m_tuser_i;
        if (pending_inverses.size() == 0) begin
          note_failure($sformatf("unexpected result inverse=%0h divisor=%0h invertible=%0b",
                                 got.inverse, got.divisor, got.invertible));
        end else begin
          want = pending_inverses.pop_front();
          if (got.inverse != want.inverse || got.divisor != want.divisor ||
              got.invertible != want.invertible) begin
            note_failure($sformatf({"inverse exp %0h got %0h, divisor exp %0h got %0h, ",
                                    "invertible exp %0b got %0b"},
                                   want.inverse, got.inverse, want.divisor, got.divisor,
                                   want.invertible, got.invertible));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pending_inverses.push_back(euclid_inverse(s_tdata_i[W-1:0], s_tdata_i[2*W-1:W]));
      end
    end
    pending_o <= pending_inverses.size();
  end

endmodule

[tb/sv/tb_modular_inverse_ext_euclid.sv]
// Testbench top for modular_inverse_ext_euclid: clock, reset, stimulus, verdict.
// Drives directed and random value/modulus items with random idling on both sides.
// Depends on mie_pkg, modular_inverse_ext_euclid and mie_inverse_checker.
module tb_modular_inverse_ext_euclid;
  import mie_pkg::*;

  localparam int unsigned W           = DEF_WIDTH;
  localparam int unsigned DW          = ((2*W+7)/8)*8;
  localparam int          RANDOM_ITEMS = 268;
  localparam int          QUIET_ITEMS  = 40;
  localparam int          HOLD_AT      = 90;
  localparam int          HOLD_CYCLES  = 6000;
  localparam int          DRAIN_CYCLES = 2000;
  localparam int          CYCLE_LIMIT  = 2500000;

  localparam logic [W-1:0] MAX_VAL = '1;
  // consecutive Fibonacci numbers give the longest run of Euclid steps
  localparam logic [W-1:0] FIB_HI  = 32'd2971215073;
  localparam logic [W-1:0] FIB_LO  = 32'd1836311903;

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [DW-1:0] s_axis_tdata  = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;
  logic          m_axis_tuser;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  bit quiet       = 1'b0;
  bit hold_now    = 1'b0;
  bit hold_done   = 1'b0;

  always #10 clk_i = ~clk_i;

  modular_inverse_ext_euclid #(
    .WIDTH(W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  mie_inverse_checker #(
    .W (W),
    .DW(DW)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  // Offer one item, with an optional idle burst first, and wait for acceptance
  task automatic offer_item(input logic [W-1:0] value, input logic [W-1:0] modulus);
    logic [DW-1:0] packed_item;
    packed_item = '0;
    packed_item[W-1:0]   = value;
    packed_item[2*W-1:W] = modulus;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= packed_item;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Random operand pair, biased toward small moduli and shared factors
  task automatic offer_random_item();
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    logic [W-1:0] factor;
    case ($urandom_range(0, 9))
      0, 1: begin
        value   = $urandom();
        modulus = $urandom_range(1, 255);
      end
      2, 3: begin
        factor  = $urandom_range(2, 65535);
        value   = factor * $urandom_range(0, 65535);
        modulus = factor * $urandom_range(1, 65535);
      end
      4: begin
        value   = $urandom_range(0, 3);
        modulus = $urandom();
      end
      5: begin
        value   = $urandom();
        modulus = MAX_VAL - $urandom_range(0, 15);
      end
      default: begin
        value   = $urandom();
        modulus = $urandom();
      end
    endcase
    if (modulus == 0) begin
      modulus = 1;
    end
    offer_item(value, modulus);
  endtask

  // Receiver: random stall bursts, one long hold-off, none in the quiet tail
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_now && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 32)) @(posedge clk_i);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_modular_inverse_ext_euclid failed");
    $finish;
  end

  // Reset, stimulus and verdict
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and special cases
    offer_item(0, 1);               // value zero, modulus of one
    offer_item(5, 1);               // modulus of one
    offer_item(MAX_VAL, 1);
    offer_item(0, 7);               // value zero, no inverse
    offer_item(0, MAX_VAL);
    offer_item(1, MAX_VAL);
    offer_item(3, 7);
    offer_item(7, 3);               // value above modulus
    offer_item(6, 9);               // shared factor, no inverse
    offer_item(MAX_VAL, MAX_VAL);   // value equals modulus
    offer_item(MAX_VAL - 1, MAX_VAL);
    offer_item(MAX_VAL, MAX_VAL - 1);
    offer_item(2, 32'h8000_0000);
    offer_item(32'h8000_0001, 32'h8000_0000);
    offer_item(FIB_LO, FIB_HI);     // longest step sequence
    offer_item(FIB_HI, FIB_LO);
    offer_item(1, 2);
    offer_item(12345, 65537);
    offer_item(32'h5555_5555, 32'hAAAA_AAAB);
    offer_item(32'hAAAA_AAAA, 32'h5555_5555);
    offer_item(32'h0001_0000, 32'hFFFF_0000);
    offer_item(MAX_VAL, 2);

    // random part; long receiver hold-off early, no idling at the end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) begin
        hold_now = 1'b1;
      end
      if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
        quiet = 1'b1;
      end
      offer_random_item();
    end
    s_axis_tvalid <= 1'b0;

    // drain: wait for every result, then let the block settle
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_modular_inverse_ext_euclid passed");
    end else begin
      $display("tb_modular_inverse_ext_euclid failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mie_pkg.sv
sv/mie_ctrl.sv
sv/mie_dpath.sv
sv/modular_inverse_ext_euclid.sv
tb/sv/mie_inverse_checker.sv
tb/sv/tb_modular_inverse_ext_euclid.sv
